[design/mrs_pkg.sv]
// shared types, constants and sha-256 helper functions for the merkle root block
// no dependencies; used by mrs_front, mrs_back and merkle_root_sha256_unit
package mrs_pkg;

	// widest fields needed over the whole parameter range
	localparam int AddrMax  = 18;
	localparam int CountMax = 17;

	typedef struct packed {
		logic [63:0]          word;
		logic                 wr;
		logic [AddrMax-1:0]   addr;
		logic                 fin;
		logic [CountMax-1:0]  count;
		logic                 ovf;
	} cmd_t;

	typedef struct packed {
		logic [63:0] word;
		logic        last;
		logic        ovf;
	} res_t;

	localparam logic [31:0] PadWord = 32'h8000_0000;

	function automatic logic [31:0] init_h(input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
			6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
			6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// padding word pair for slot j of a single-node (32-byte) message
	function automatic logic [63:0] pad_pair(input logic [2:0] j);
		logic [63:0] r;
		case (j)
			3'd4: r = {PadWord, 32'd0};
			3'd7: r = {32'd0, 32'd256};
			default: r = 64'd0;
		endcase
		return r;
	endfunction

endpackage

[design/mrs_fifo.sv]
// small four-entry register queue used between front, back and result ports
// depends on nothing
module mrs_fifo #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	logic [Width-1:0] slot_q [4];
	logic [1:0]       wp_q, rp_q;
	logic [2:0]       cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == 3'd4);
	assign empty   = (cnt_q == 3'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 2'd1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd0 || cnt_q == 3'd4) |-> (wp_q == rp_q))
		else $error("queue pointers disagree with count");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_rd |=> full)
		else $error("full queue lost an entry");

endmodule

[design/mrs_front.sv]
// front part: counts words and leaves, decides store address, overflow and end of set
// depends on mrs_pkg
module mrs_front #(
	parameter int MAX_LEAVES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [63:0]       hash_word,
	input  logic              last_leaf,
	output mrs_pkg::cmd_t     cmd
);
	import mrs_pkg::*;

	localparam int AW = $clog2(4 * MAX_LEAVES);
	localparam int CW = $clog2(MAX_LEAVES + 1);

	logic [CW-1:0] leaf_cnt_q;
	logic [1:0]    phase_q;
	logic          ovf_q;
	logic          room;
	logic          fin;
	logic [CW-1:0] cnt_next;

	assign room     = (leaf_cnt_q < CW'(MAX_LEAVES));
	assign fin      = (phase_q == 2'd3) && last_leaf;
	assign cnt_next = (room && phase_q == 2'd3) ? leaf_cnt_q + CW'(1) : leaf_cnt_q;

	always_comb begin
		cmd       = '0;
		cmd.word  = hash_word;
		cmd.wr    = room;
		cmd.addr  = AddrMax'({leaf_cnt_q[AW-3:0], phase_q});
		cmd.fin   = fin;
		cmd.count = CountMax'(cnt_next);
		cmd.ovf   = ovf_q || !room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_cnt_q <= '0;
			phase_q    <= 2'd0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_q + 2'd1;
			if (fin) begin
				leaf_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end else begin
				leaf_cnt_q <= cnt_next;
				ovf_q      <= ovf_q || !room;
			end
		end
	end

endmodule

[design/mrs_back.sv]
// back part: node store, sha-256 round engine and level-by-level reduction sequencer
// depends on mrs_pkg
module mrs_back #(
	parameter int MAX_LEAVES = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mrs_pkg::cmd_t  cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	input  logic           res_empty,
	output logic           res_push,
	output mrs_pkg::res_t  res
);
	import mrs_pkg::*;

	localparam int AW = $clog2(4 * MAX_LEAVES);
	localparam int CW = $clog2(MAX_LEAVES + 1);
	localparam int SW = 4 * MAX_LEAVES;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_COMP  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_OWAIT = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [63:0]   store [SW];
	logic [63:0]   rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [63:0]   wdata;

	logic [2:0]    st_q;
	logic [CW-1:0] n_q, m_q;
	logic [CW:0]   i_q;
	logic          ovf_q, blk_q;
	logic [3:0]    ld_q;
	logic [5:0]    rnd_q;
	logic [1:0]    wk_q;
	logic [31:0]   w_q [16];
	logic [31:0]   h_q [8];
	logic [31:0]   v_q [8];

	logic          pair;
	logic [CW:0]   i_nxt;
	logic [CW-1:0] node_rd;
	logic [2:0]    ld_item;
	logic [63:0]   ld_word;
	logic [31:0]   t1, t2, w_new;

	assign i_nxt   = i_q + (CW+1)'(2);
	assign pair    = (i_q + (CW+1)'(1)) < {1'b0, n_q};
	assign node_rd = ld_q[2] ? CW'(i_q + (CW+1)'(1)) : CW'(i_q);
	assign ld_item = 3'(ld_q - 4'd1);
	assign ld_word = (pair || ld_item < 3'd4) ? rdata_q : pad_pair(ld_item);

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(rnd_q) + w_q[0];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];

	assign cmd_pop  = (st_q == S_IDLE) && !cmd_empty;
	assign res_push = (st_q == S_OUT) && (ld_q != 4'd0);
	always_comb begin
		res.word = rdata_q;
		res.last = (ld_q == 4'd4);
		res.ovf  = ovf_q;
	end

	// store port muxing
	always_comb begin
		raddr = '0;
		if (st_q == S_LOAD) begin
			raddr = {node_rd[AW-3:0], ld_q[1:0]};
		end else if (st_q == S_OUT) begin
			raddr = AW'(ld_q[1:0]);
		end
		we    = 1'b0;
		waddr = AW'(cmd.addr);
		wdata = cmd.word;
		if (st_q == S_WRITE) begin
			we    = 1'b1;
			waddr = {m_q[AW-3:0], wk_q};
			wdata = {h_q[{wk_q, 1'b0}], h_q[{wk_q, 1'b1}]};
		end else if (cmd_pop && cmd.wr) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		rdata_q <= store[raddr];
	end

	// message schedule, working and digest registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				for (int k = 0; k < 8; k++) begin
					h_q[k] <= init_h(3'(k));
				end
			end
			S_WRITE: begin
				// digest stays until its last word pair is written
				if (wk_q == 2'd3) begin
					for (int k = 0; k < 8; k++) begin
						h_q[k] <= init_h(3'(k));
					end
				end
			end
			S_LOAD: begin
				if (ld_q != 4'd0) begin
					for (int k = 0; k < 14; k++) begin
						w_q[k] <= w_q[k+2];
					end
					w_q[14] <= ld_word[63:32];
					w_q[15] <= ld_word[31:0];
				end
				if (ld_q == 4'd8) begin
					for (int k = 0; k < 8; k++) begin
						v_q[k] <= h_q[k];
					end
				end
			end
			S_COMP: begin
				for (int k = 0; k < 15; k++) begin
					w_q[k] <= w_q[k+1];
				end
				w_q[15] <= w_new;
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
			end
			S_FIN: begin
				for (int k = 0; k < 8; k++) begin
					h_q[k] <= h_q[k] + v_q[k];
					v_q[k] <= h_q[k] + v_q[k];
				end
				// length block of a 64-byte message
				w_q[0] <= PadWord;
				for (int k = 1; k < 15; k++) begin
					w_q[k] <= '0;
				end
				w_q[15] <= 32'd512;
			end
			default: begin
			end
		endcase
	end

	// reduction sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			n_q   <= '0;
			m_q   <= '0;
			i_q   <= '0;
			ovf_q <= 1'b0;
			blk_q <= 1'b0;
			ld_q  <= '0;
			rnd_q <= '0;
			wk_q  <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (cmd_pop && cmd.fin) begin
						n_q   <= CW'(cmd.count);
						ovf_q <= cmd.ovf;
						i_q   <= '0;
						m_q   <= '0;
						ld_q  <= '0;
						blk_q <= 1'b0;
						st_q  <= (cmd.count == CountMax'(1)) ? S_OWAIT : S_LOAD;
					end
				end
				S_LOAD: begin
					ld_q <= ld_q + 4'd1;
					if (ld_q == 4'd8) begin
						rnd_q <= '0;
						st_q  <= S_COMP;
					end
				end
				S_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (pair && !blk_q) begin
						blk_q <= 1'b1;
						rnd_q <= '0;
						st_q  <= S_COMP;
					end else begin
						wk_q <= '0;
						st_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					wk_q <= wk_q + 2'd1;
					if (wk_q == 2'd3) begin
						ld_q  <= '0;
						blk_q <= 1'b0;
						if (i_nxt < {1'b0, n_q}) begin
							i_q  <= i_nxt;
							m_q  <= m_q + CW'(1);
							st_q <= S_LOAD;
						end else if (m_q != '0) begin
							n_q  <= m_q + CW'(1);
							i_q  <= '0;
							m_q  <= '0;
							st_q <= S_LOAD;
						end else begin
							st_q <= S_OWAIT;
						end
					end
				end
				S_OWAIT: begin
					if (res_empty) begin
						ld_q <= '0;
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					ld_q <= ld_q + 4'd1;
					if (ld_q == 4'd4) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> st_q == S_IDLE)
		else $error("command taken while reducing");
	a_comp_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_COMP && rnd_q == 6'd63) |=> st_q == S_FIN)
		else $error("compression did not end after 64 rounds");
	a_last_once: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last) |=> st_q == S_IDLE)
		else $error("root not closed after fourth word");

endmodule

[design/merkle_root_sha256_unit.sv]
// top level of the merkle root block: input queue port, front, command queue, back, result queue
// depends on mrs_pkg, mrs_fifo, mrs_front, mrs_back
//
// Leaf hashes stream in one 64-bit word per cycle while the command queue is not full, four
// words per leaf, and are written to an on-chip node store of 4*MAX_LEAVES words; leaves
// past MAX_LEAVES are dropped and flagged on the root. After the fourth word of the leaf
// marked last, the back end reduces the tree with one sha-256 round engine doing one round
// per clock: each node hash takes 8 store reads, then 64 rounds and a finish step per
// compression (two compressions for a pair, one for an odd node), then 4 word-pair writes,
// repeated level by level. The four root words then leave through a four-entry result queue.
// While the back end reduces, the four-entry command queue fills and full rises until the
// root has been handed to the result queue.
module merkle_root_sha256_unit #(
	parameter int MAX_LEAVES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic        push,
	output logic        full,
	input  logic [63:0] hash_word,
	input  logic        last_leaf,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output logic [63:0] root_word,
	output logic        last_word,
	output logic        overflow
);
	import mrs_pkg::*;

	cmd_t cmd_in, cmd_out;
	res_t res_in, res_out;
	logic cmd_empty, cmd_pop;
	logic res_push, res_full;
	logic accept;

	// a beat is taken when push is high and the command queue has room
	assign accept = push && !full;

	mrs_front #(.MAX_LEAVES(MAX_LEAVES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.hash_word (hash_word),
		.last_leaf (last_leaf),
		.cmd       (cmd_in)
	);

	// decouples word intake from the reduction engine
	mrs_fifo #(.Width($bits(cmd_t))) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (full),
		.empty   (cmd_empty)
	);

	mrs_back #(.MAX_LEAVES(MAX_LEAVES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_empty (empty),
		.res_push  (res_push),
		.res       (res_in)
	);

	// root words wait here; back end only starts pushing a root's words when this is empty
	mrs_fifo #(.Width($bits(res_t))) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_out),
		.full    (res_full),
		.empty   (empty)
	);

	assign root_word = res_out.word;
	assign last_word = res_out.last;
	assign overflow  = res_out.ovf;

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("root word pushed into full result queue");
	a_last_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_word) |=> !empty)
		else $error("root words split apart in result queue");
	a_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd_out.fin) |=> !cmd_pop)
		else $error("command taken during reduction start");

endmodule
